/* hdl/pse_pkg.sv */
// Postfix stack evaluator: shared codes and types.
// Mode and status encodings, and the request bundle of the multiply/divide unit.
// No dependencies.
`default_nettype none

package pse_pkg;

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_PUSH = 3'd0;
  localparam mode_t MODE_ADD  = 3'd1;
  localparam mode_t MODE_SUB  = 3'd2;
  localparam mode_t MODE_MUL  = 3'd3;
  localparam mode_t MODE_DIV  = 3'd4;
  localparam mode_t MODE_SUM  = 3'd5;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_UNDERFLOW = 2'd1;
  localparam status_t ST_DIVZERO   = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

endpackage

`default_nettype wire

/* hdl/pse_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/pse_mdu.sv */
// Iterative multiply / truncating signed divide unit, one bit per cycle.
// Depends on pse_pkg (request bundle).
`default_nettype none

module pse_mdu #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pse_pkg::mdu_req_t     req_i,
  input  wire logic [DATA_WIDTH-1:0] a_i,
  input  wire logic [DATA_WIDTH-1:0] b_i,
  output logic                       done_o,
  output logic      [DATA_WIDTH-1:0] res_o
);

  import pse_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int SW = $clog2(DW + 1);

  logic          busy_q, done_q;
  logic [SW-1:0] step_q;
  logic          div_q, neg_q;
  logic [DW-1:0] acc_q, x_q, y_q;
  logic [DW:0]   rem_q;

  logic [DW-1:0] a_mag, b_mag;
  logic [DW:0]   trial;
  logic          fits;

  assign a_mag = a_i[DW-1] ? (~a_i + DW'(1)) : a_i;
  assign b_mag = b_i[DW-1] ? (~b_i + DW'(1)) : b_i;
  assign trial = {rem_q[DW-1:0], x_q[DW-1]};
  assign fits  = (trial >= {1'b0, y_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= SW'(DW);
      end else if (busy_q) begin
        step_q <= step_q - SW'(1);
        if (step_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      div_q <= req_i.is_div;
      neg_q <= a_i[DW-1] ^ b_i[DW-1];
      acc_q <= '0;
      rem_q <= '0;
      x_q   <= req_i.is_div ? a_mag : a_i;
      y_q   <= req_i.is_div ? b_mag : b_i;
    end else if (busy_q) begin
      if (div_q) begin
        rem_q <= fits ? (trial - {1'b0, y_q}) : trial;
        x_q   <= {x_q[DW-2:0], fits};
      end else begin
        if (y_q[0]) begin
          acc_q <= acc_q + x_q;
        end
        x_q <= {x_q[DW-2:0], 1'b0};
        y_q <= {1'b0, y_q[DW-1:1]};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = div_q ? (neg_q ? (~x_q + DW'(1)) : x_q) : acc_q;

endmodule

`default_nettype wire

/* hdl/postfix_stack_evaluator.sv */
// Postfix stack evaluator top level: sequencer, stack memory and output register.
// Depends on pse_pkg, pse_ram, pse_mdu.
//
// Evaluates integer expressions in postfix order on an operand stack held in a
// single synchronous RAM; a copy of the top entry and the stack pointer live in
// flops. One transaction is worked on at a time; each produces one result with
// the new top of stack (zero when empty), the depth and a status. Push, an unused
// mode or any flagged transaction go from accept straight to the finish state;
// add and sub read the second operand and then compute; mul and div wait on the
// bit-serial multiply/divide unit; sum reads its entries one stack RAM read per
// cycle. A finished result waits while the output register still holds an
// unaccepted one; the output register lets the next transaction be taken while
// a result waits downstream.
`default_nettype none

module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // value [DATA_WIDTH-1:0], count above it, zero pad to bytes
  input  wire logic [((DATA_WIDTH + $clog2(STACK_DEPTH + 1) + 7) / 8) * 8 - 1:0] s_tdata,
  // mode
  input  wire logic [pse_pkg::MODE_W-1:0]    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // top_value [DATA_WIDTH-1:0], depth above it, zero pad to bytes
  output logic      [((DATA_WIDTH + $clog2(STACK_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
  // status
  output logic      [pse_pkg::STATUS_W-1:0]  m_tuser
);

  import pse_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int TW = ((DW + PW + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_MDU,
    S_SUM,
    S_FIN
  } state_e;

  state_e          state_q, state_d;
  logic [PW-1:0]   sp_q, sp_d;
  logic            m_valid_q, m_valid_d;
  logic [TW-1:0]   m_data_q, m_data_d;
  status_t         m_user_q, m_user_d;
  logic            rvalid_q, rvalid_d;

  logic [DW-1:0]   top_q, top_d;
  mode_t           mode_q, mode_d;
  logic [PW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [DW-1:0]   acc_q, acc_d;
  logic [DW-1:0]   res_q, res_d;
  logic            wb_q, wb_d;
  logic [AW-1:0]   wb_addr_q, wb_addr_d;
  logic [PW-1:0]   wb_sp_q, wb_sp_d;
  status_t         status_q, status_d;

  mode_t           in_mode;
  logic [DW-1:0]   in_value;
  logic [PW-1:0]   in_count;
  logic [PW-1:0]   sp_m1, sp_m2, sp_mc;
  logic            full;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [DW-1:0]   ram_rdata;

  mdu_req_t        mdu_req;
  logic            mdu_done;
  logic [DW-1:0]   mdu_res;

  logic [DW-1:0]   out_top;
  logic [PW-1:0]   out_depth;

  assign in_mode  = s_tuser;
  assign in_value = s_tdata[DW-1:0];
  assign in_count = s_tdata[DW+PW-1:DW];

  assign sp_m1 = sp_q - PW'(1);
  assign sp_m2 = sp_q - PW'(2);
  assign sp_mc = sp_q - in_count;
  assign full  = (sp_q == PW'(STACK_DEPTH));

  assign s_tready = (state_q == S_IDLE);

  pse_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wb_addr_q),
    .wdata_i (res_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pse_mdu #(
    .DATA_WIDTH (DW)
  ) u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .a_i    (ram_rdata),
    .b_i    (top_q),
    .done_o (mdu_done),
    .res_o  (mdu_res)
  );

  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    top_d     = top_q;
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    addr_d    = addr_q;
    res_d     = res_q;
    wb_d      = wb_q;
    wb_addr_d = wb_addr_q;
    wb_sp_d   = wb_sp_q;
    status_d  = status_q;
    rvalid_d  = 1'b0;
    acc_d     = rvalid_q ? (acc_q + ram_rdata) : acc_q;
    m_valid_d = m_tready ? 1'b0 : m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = addr_q;
    mdu_req   = '0;
    out_top   = '0;
    out_depth = '0;

    case (state_q)
      S_IDLE: begin
        if (s_tvalid) begin
          mode_d   = in_mode;
          wb_d     = 1'b0;
          status_d = ST_OK;
          state_d  = S_FIN;
          case (in_mode)
            MODE_PUSH: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                wb_d      = 1'b1;
                wb_addr_d = sp_q[AW-1:0];
                wb_sp_d   = sp_q + PW'(1);
                res_d     = in_value;
              end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
              if (sp_q < PW'(2)) begin
                status_d = ST_UNDERFLOW;
              end else if ((in_mode == MODE_DIV) && (top_q == '0)) begin
                status_d = ST_DIVZERO;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = sp_m2[AW-1:0];
                wb_d      = 1'b1;
                wb_addr_d = sp_m2[AW-1:0];
                wb_sp_d   = sp_m1;
                state_d   = S_OP;
              end
            end
            MODE_SUM: begin
              if (in_count > sp_q) begin
                status_d = ST_UNDERFLOW;
              end else if ((in_count == '0) && full) begin
                status_d = ST_FULL;
              end else begin
                cnt_d     = in_count;
                addr_d    = sp_m1[AW-1:0];
                acc_d     = '0;
                wb_d      = 1'b1;
                wb_addr_d = sp_mc[AW-1:0];
                wb_sp_d   = sp_mc + PW'(1);
                state_d   = S_SUM;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_OP: begin
        case (mode_q)
          MODE_ADD: begin
            res_d   = ram_rdata + top_q;
            state_d = S_FIN;
          end
          MODE_SUB: begin
            res_d   = ram_rdata - top_q;
            state_d = S_FIN;
          end
          MODE_MUL, MODE_DIV: begin
            mdu_req.start  = 1'b1;
            mdu_req.is_div = (mode_q == MODE_DIV);
            state_d        = S_MDU;
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_MDU: begin
        if (mdu_done) begin
          res_d   = mdu_res;
          state_d = S_FIN;
        end
      end
      S_SUM: begin
        // reads issue one per cycle; the adder takes each read's data in the cycle after it
        if (cnt_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = addr_q;
          addr_d    = addr_q - AW'(1);
          cnt_d     = cnt_q - PW'(1);
          rvalid_d  = 1'b1;
        end else if (!rvalid_q) begin
          res_d   = acc_q;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!m_valid_q || m_tready) begin
          if (wb_q) begin
            ram_we    = 1'b1;
            sp_d      = wb_sp_q;
            top_d     = res_q;
            out_top   = res_q;
            out_depth = wb_sp_q;
          end else begin
            out_top   = (sp_q == '0) ? '0 : top_q;
            out_depth = sp_q;
          end
          m_valid_d            = 1'b1;
          m_data_d             = '0;
          m_data_d[DW-1:0]     = out_top;
          m_data_d[DW+PW-1:DW] = out_depth;
          m_user_d             = status_q;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sp_q      <= '0;
      rvalid_q  <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= ST_OK;
    end else begin
      state_q   <= state_d;
      sp_q      <= sp_d;
      rvalid_q  <= rvalid_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    mode_q    <= mode_d;
    cnt_q     <= cnt_d;
    addr_q    <= addr_d;
    acc_q     <= acc_d;
    res_q     <= res_d;
    wb_q      <= wb_d;
    wb_addr_q <= wb_addr_d;
    wb_sp_q   <= wb_sp_d;
    status_q  <= status_d;
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = m_data_q;
  assign m_tuser  = m_user_q;

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= PW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_full_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && (m_tuser == ST_FULL)) |-> (m_tdata[DW+PW-1:DW] == PW'(STACK_DEPTH)))
    else $error("stack full reported below full depth");

  a_divzero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && (m_tuser == ST_DIVZERO)) |-> (m_tdata[DW+PW-1:DW] >= PW'(2)))
    else $error("divide by zero reported with fewer than two operands");

  a_mdu_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_done |-> (state_q == S_MDU))
    else $error("multiply/divide result outside its wait state");

endmodule

`default_nettype wire
